// File: hw/rtl/vibration_alarm_detector_core_assert.svh
// Assertion macros for the checker file.
`ifndef VIBRATION_ALARM_DETECTOR_CORE_ASSERT_SVH
`define VIBRATION_ALARM_DETECTOR_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define VAD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is held.
`define VAD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// File: hw/rtl/vad_pkg.sv
`timescale 1ns / 1ps
package vad_pkg;

  localparam int SAMPLE_W   = 15;
  localparam int LIMIT_W    = 14;
  localparam int LEVEL_W    = 16;
  localparam int RUN_W      = 2;
  localparam int ABSD_W     = 15;
  localparam int SUM_W      = 32;
  localparam int REM_W      = 18;
  localparam int ALU_W      = 20;
  localparam int AXES       = 3;
  localparam int AXIS_W     = 2;
  localparam int ITER_W     = 4;
  localparam int ROOT_STEPS = SUM_W / 2;

  localparam int ALARM_COUNT_DEF = 3;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 14'd1000;

  localparam int REG_IDX_W = 1;
  localparam int PADDR_W   = REG_IDX_W + 2;
  localparam logic [REG_IDX_W-1:0] REG_VIBRATION_LIMIT = 1'd0;

  typedef logic [AXES-1:0][SAMPLE_W-1:0] axis_vec_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DELTA,
    ST_SQACC,
    ST_ROOT,
    ST_DONE
  } vad_state_t;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_DELTA,
    OP_SQACC,
    OP_ROOT
  } vad_op_t;

  typedef struct packed {
    vad_op_t           op;
    logic              clear;
    logic [AXIS_W-1:0] axis;
    logic              finish;
    logic              idle;
  } vad_ctrl_t;

endpackage

// File: hw/rtl/vibration_alarm_detector_core.sv
`timescale 1ns / 1ps
// Vibration alarm detector.
// Input channel (in_valid/in_ready): one three-axis sample in signed milli-g per
// transaction. Result channel (out_valid/out_ready): vibration level, the run
// of consecutive at-or-over-limit samples and the alarm flag, one result per
// sample. The level is the floor square root of the summed squared deltas to
// the previous sample; the first sample after reset yields 0.
// in_ready is high only while the sequencer is idle, so the block takes no
// new sample until the last one has passed all its steps: 3 delta and 3
// square-accumulate steps on the shared subtractor and multiplier, 16
// bit-pair steps of the square-root loop on the same subtractor, the done
// state that posts the result, and the idle state that takes the next
// transaction.
// A finished result is held in the output register; the next sample may be
// accepted while it waits. If the receiver stalls, the following result waits
// in its last step until the output register is free.
// Configuration: APB register 0 (byte address 0) holds vibration_limit, 14
// bits, reset 1000. pready is always high. Write only while idle.
// Reset (rst_n low, synchronous) clears the previous sample, the run counter,
// the sequencer and out_valid, and restores the limit.
module vibration_alarm_detector_core
  import vad_pkg::*;
#(
  parameter int ALARM_COUNT = ALARM_COUNT_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [SAMPLE_W-1:0] in_accel_x,
  input  logic [SAMPLE_W-1:0] in_accel_y,
  input  logic [SAMPLE_W-1:0] in_accel_z,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [LEVEL_W-1:0]  out_vibration_level,
  output logic [RUN_W-1:0]    out_abnormal_run,
  output logic                out_alarm,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int CNT_W = $clog2(ALARM_COUNT + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(ALARM_COUNT);

  vad_ctrl_t          ctrl;
  logic               start;
  logic               out_free;
  logic [LEVEL_W-1:0] root;

  logic [LIMIT_W-1:0] limit_r;
  axis_vec_t          sample_r;
  axis_vec_t          last_r;
  logic               have_last_r;
  logic [CNT_W-1:0]   over_r, over_nxt;
  logic               out_valid_r;
  logic [LEVEL_W-1:0] out_level_r;
  logic [RUN_W-1:0]   out_run_r;
  logic               out_alarm_r;

  logic [LEVEL_W-1:0] level;
  logic               hit;
  logic [CNT_W+RUN_W-1:0] over_ext;
  logic               cfg_wr;

  assign start    = in_valid & in_ready;
  assign out_free = ~out_valid_r | out_ready;
  assign in_ready = ctrl.idle;

  vad_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .out_free (out_free),
    .ctrl     (ctrl)
  );

  vad_dp u_dp (
    .clk    (clk),
    .ctrl   (ctrl),
    .sample (sample_r),
    .last   (last_r),
    .root   (root)
  );

  // configuration register
  assign cfg_wr = psel & penable & pwrite & pready;
  assign pready = 1'b1;
  assign prdata = (paddr[PADDR_W-1:2] == REG_VIBRATION_LIMIT) ?
                  32'(limit_r) : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (cfg_wr && paddr[PADDR_W-1:2] == REG_VIBRATION_LIMIT) begin
      limit_r <= pwdata[LIMIT_W-1:0];
    end
  end

  // hold the sample for the whole computation
  always_ff @(posedge clk) begin
    if (start) begin
      sample_r <= {in_accel_z, in_accel_y, in_accel_x};
    end
  end

  // level is forced to zero when no previous sample exists
  assign level    = have_last_r ? root : '0;
  assign hit      = level >= LEVEL_W'(limit_r);
  assign over_nxt = !hit ? '0 : (over_r < CNT_MAX) ? over_r + 1'b1 : over_r;
  assign over_ext = {{RUN_W{1'b0}}, over_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r      <= '0;
      have_last_r <= 1'b0;
      over_r      <= '0;
    end else if (ctrl.finish) begin
      last_r      <= sample_r;
      have_last_r <= 1'b1;
      over_r      <= over_nxt;
    end
  end

  // output register: set on finish, drop on transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.finish) begin
      out_level_r <= level;
      out_run_r   <= over_ext[RUN_W-1:0];
      out_alarm_r <= (over_nxt == CNT_MAX);
    end
  end

  assign out_valid           = out_valid_r;
  assign out_vibration_level = out_level_r;
  assign out_abnormal_run    = out_run_r;
  assign out_alarm           = out_alarm_r;

endmodule

// File: hw/rtl/vad_ctrl.sv
`timescale 1ns / 1ps
module vad_ctrl
  import vad_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      out_free,
  output vad_ctrl_t ctrl
);

  vad_state_t        state_r, state_nxt;
  logic [AXIS_W-1:0] axis_r, axis_nxt;
  logic [ITER_W-1:0] iter_r, iter_nxt;

  localparam logic [AXIS_W-1:0] LAST_AXIS = AXIS_W'(AXES - 1);
  localparam logic [ITER_W-1:0] LAST_ITER = ITER_W'(ROOT_STEPS - 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      axis_r  <= '0;
      iter_r  <= '0;
    end else begin
      state_r <= state_nxt;
      axis_r  <= axis_nxt;
      iter_r  <= iter_nxt;
    end
  end

  // next state and counters
  always_comb begin
    state_nxt = state_r;
    axis_nxt  = axis_r;
    iter_nxt  = iter_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_DELTA;
          axis_nxt  = '0;
        end
      end
      ST_DELTA: state_nxt = ST_SQACC;
      ST_SQACC: begin
        if (axis_r == LAST_AXIS) begin
          state_nxt = ST_ROOT;
          iter_nxt  = '0;
        end else begin
          state_nxt = ST_DELTA;
          axis_nxt  = axis_r + 1'b1;
        end
      end
      ST_ROOT: begin
        iter_nxt = iter_r + 1'b1;
        if (iter_r == LAST_ITER) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ctrl.op     = OP_NONE;
    ctrl.clear  = 1'b0;
    ctrl.axis   = axis_r;
    ctrl.finish = 1'b0;
    ctrl.idle   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        ctrl.idle  = 1'b1;
        ctrl.clear = start;
      end
      ST_DELTA: ctrl.op     = OP_DELTA;
      ST_SQACC: ctrl.op     = OP_SQACC;
      ST_ROOT:  ctrl.op     = OP_ROOT;
      ST_DONE:  ctrl.finish = out_free;
      default:  ctrl.op     = OP_NONE;
    endcase
  end

endmodule

// File: hw/rtl/vad_dp.sv
`timescale 1ns / 1ps
module vad_dp
  import vad_pkg::*;
(
  input  logic               clk,
  input  vad_ctrl_t          ctrl,
  input  axis_vec_t          sample,
  input  axis_vec_t          last,
  output logic [LEVEL_W-1:0] root
);

  logic [ABSD_W-1:0]  absd_r;
  logic [SUM_W-1:0]   sum_r;
  logic [REM_W-1:0]   rem_r;
  logic [LEVEL_W-1:0] root_r;

  logic [SAMPLE_W-1:0] cur_s, last_s;
  logic [ALU_W-1:0]    alu_a, alu_b, alu_diff;
  logic [ALU_W-1:0]    neg_diff;
  logic [2*ABSD_W-1:0] prod;

  assign cur_s  = sample[ctrl.axis];
  assign last_s = last[ctrl.axis];

  // shared subtractor: axis delta or trial subtraction of the root step
  always_comb begin
    if (ctrl.op == OP_ROOT) begin
      alu_a = {sum_r[SUM_W-1 -: 2], rem_r} == '0 ? '0 : ALU_W'({rem_r, sum_r[SUM_W-1 -: 2]});
      alu_b = ALU_W'({root_r, 2'b01});
    end else begin
      alu_a = {{(ALU_W-SAMPLE_W){cur_s[SAMPLE_W-1]}}, cur_s};
      alu_b = {{(ALU_W-SAMPLE_W){last_s[SAMPLE_W-1]}}, last_s};
    end
  end

  assign alu_diff = alu_a - alu_b;
  assign neg_diff = '0 - alu_diff;
  assign prod     = absd_r * absd_r;

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      sum_r  <= '0;
      rem_r  <= '0;
      root_r <= '0;
    end else begin
      unique case (ctrl.op)
        OP_DELTA: begin
          absd_r <= alu_diff[ALU_W-1] ? neg_diff[ABSD_W-1:0] : alu_diff[ABSD_W-1:0];
        end
        OP_SQACC: sum_r <= sum_r + SUM_W'(prod);
        OP_ROOT: begin
          // shift the next bit pair out of the radicand
          sum_r <= {sum_r[SUM_W-3:0], 2'b00};
          if (!alu_diff[ALU_W-1]) begin
            rem_r  <= alu_diff[REM_W-1:0];
            root_r <= {root_r[LEVEL_W-2:0], 1'b1};
          end else begin
            rem_r  <= alu_a[REM_W-1:0];
            root_r <= {root_r[LEVEL_W-2:0], 1'b0};
          end
        end
        OP_NONE: sum_r <= sum_r;
        default: sum_r <= sum_r;
      endcase
    end
  end

  assign root = root_r;

endmodule

// File: hw/rtl/vad_checker.sv
`timescale 1ns / 1ps
`include "vibration_alarm_detector_core_assert.svh"
module vad_checker
  import vad_pkg::*;
#(
  parameter int ALARM_COUNT = ALARM_COUNT_DEF
) (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [RUN_W-1:0] out_abnormal_run,
  input logic             out_alarm
);

  localparam logic [RUN_W-1:0] RUN_AT_ALARM = RUN_W'(ALARM_COUNT);

  // a stalled result stays offered
  `VAD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  // the sequencer is busy right after taking a sample
  `VAD_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)
  // alarm only with a saturated run
  `VAD_ASSERT_IMPLY(a_alarm_run, clk, rst_n, out_valid && out_alarm,
                    out_abnormal_run == RUN_AT_ALARM)

endmodule

bind vibration_alarm_detector_core vad_checker #(.ALARM_COUNT(ALARM_COUNT)) u_vad_checker (.*);
